[hw/rtl/gqtl_pkg.sv]
// Shared types, constants and helper functions for the glyph quad text layout unit.
package gqtl_pkg;

    localparam int FIRST_CODE  = 32;
    localparam int GLYPH_COUNT = 95;
    localparam int GIDX_W      = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

    localparam int CODE_W  = 8;
    localparam int POS_W   = 24;   // Q16.8 positions
    localparam int EDGE_W  = 16;   // integer pixel edges
    localparam int MULT_W  = 22;   // size multiplier, Q6.16 unsigned
    localparam int CFG_W   = 24;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 152;

    // m = scale * 10 / 48 in Q6.16 is scale * 160 / 3, rounded
    localparam int MULT_NUM    = 160;
    localparam int MULT_DEN    = 3;
    localparam int RECIP_SHIFT = 25;
    localparam logic [24:0] RECIP = 25'(((64'd1 << RECIP_SHIFT) + MULT_DEN - 1) / MULT_DEN);

    localparam logic [15:0]       SCALE_RESET = 16'd256;
    localparam logic [MULT_W-1:0] MULT_RESET  =
        MULT_W'((int'(SCALE_RESET) * MULT_NUM + 1) / MULT_DEN);

    // advance of a code outside the glyph set: 10.0 in Q8.8
    localparam logic [15:0] OOR_ADVANCE = 16'd2560;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_PLACE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CFG_ORIGIN_X    = 2'd0,
        CFG_ORIGIN_Y    = 2'd1,
        CFG_TEXT_SCALE  = 2'd2,
        CFG_FONT_ASCENT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        [15:0] adv;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic        [7:0]  w;
        logic        [7:0]  h;
        logic        [15:0] u0;
        logic        [15:0] u1;
        logic        [15:0] v0;
        logic        [15:0] v1;
    } t_glyph;

    typedef struct packed {
        logic              en;
        logic [GIDX_W-1:0] idx;
        t_glyph            data;
    } t_glyph_wr;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [17:0] hi;
        logic signed [17:0] lo;
        hi = 18'sd32767;
        lo = -18'sd32768;
        if (v > hi) begin
            return 16'sh7fff;
        end else if (v < lo) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [25:0] hi;
        logic signed [25:0] lo;
        hi = 26'sd8388607;
        lo = -26'sd8388608;
        if (v > hi) begin
            return 24'sh7fffff;
        end else if (v < lo) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

endpackage

[hw/rtl/gqtl_glyph_mem.sv]
// Glyph metric memory: one write port, one registered read port, per-entry valid bits.
module gqtl_glyph_mem
    import gqtl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_glyph_wr         i_wr,
    input  logic              i_rd_en,
    input  logic [GIDX_W-1:0] i_rd_idx,
    output t_glyph            o_rd_data
);

    t_glyph                 r_mem [GLYPH_COUNT];
    logic [GLYPH_COUNT-1:0] r_vld;
    t_glyph                 r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_idx];
            end
        end
    end

    // an entry never loaded reads as all zero: no bitmap, no advance
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

[hw/rtl/glyph_quad_text_layout_unit.sv]
// Top level of the glyph quad text layout unit.
//
// Usage: the slave stream carries items with the op in s_axis_tuser. A load item
// writes one glyph entry if its code is in the glyph set, a begin item latches
// the size multiplier and sets the pen and baseline, a place item yields one
// result on the master stream. Loads, begins and unused op codes yield nothing.
// Registers are written through the plain write port (i_cfg_we, i_cfg_idx,
// i_cfg_wdata) while the unit is idle and take effect at the next begin item.
// Throughput: one item per cycle while the master side takes results. A place item
// goes through the glyph memory read, the multipliers, the pen update, the
// left/top rounding and the right/bottom edge, in that order. A begin item takes
// the fresh multiplier and leaves the pipe after the pen update. The pen, the
// baseline and the size multiplier are carried from item to item.
// Reset: synchronous and active low; it clears all valid flags, pen, baseline,
// size multiplier and the glyph valid bits, so every glyph reads as empty.
// Stall: when m_axis_tready is low the result holds on the master side and the
// stages behind it keep filling; s_axis_tready falls only once all stages hold.
module glyph_quad_text_layout_unit
    import gqtl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // char_code, advance, bear_left, bear_top, glyph_w, glyph_h,
    // tex_u0, tex_u1, tex_v0, tex_v1
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // op
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // quad_left, quad_top, quad_right, quad_bottom, out_u0, out_u1, out_v0,
    // out_v1, pen_after
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // drawn
    output logic                   m_axis_tuser,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    // ---------------- configuration ----------------
    logic signed [POS_W-1:0] r_origin_x;
    logic signed [POS_W-1:0] r_origin_y;
    logic [15:0]             r_text_scale;
    logic [15:0]             r_font_ascent;
    logic [MULT_W-1:0]       r_m_cfg;
    logic [23:0]             scaled_num;
    logic [48:0]             recip_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_text_scale  <= SCALE_RESET;
            r_font_ascent <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:    r_origin_x    <= i_cfg_wdata;
                CFG_ORIGIN_Y:    r_origin_y    <= i_cfg_wdata;
                CFG_TEXT_SCALE:  r_text_scale  <= i_cfg_wdata[15:0];
                CFG_FONT_ASCENT: r_font_ascent <= i_cfg_wdata[15:0];
            endcase
        end
    end

    // scale * 160 + 1, then divide by 3 through the reciprocal
    assign scaled_num = 24'(r_text_scale * 24'(MULT_NUM)) + 24'd1;
    assign recip_prod = scaled_num * RECIP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_cfg <= MULT_RESET;
        end else begin
            r_m_cfg <= recip_prod[RECIP_SHIFT +: MULT_W];
        end
    end

    // ---------------- input decode ----------------
    logic [CODE_W-1:0] in_code;
    logic [CODE_W-1:0] code_off;
    logic              in_inside;
    logic              s_acc;
    t_op               in_op;
    logic              in_keep;
    t_glyph            in_glyph;
    t_glyph_wr         mem_wr;
    t_glyph            rd_glyph;
    logic [GIDX_W-1:0] rd_idx;

    assign in_code   = s_axis_tdata[7:0];
    assign code_off  = in_code - CODE_W'(FIRST_CODE);
    assign in_inside = (in_code >= CODE_W'(FIRST_CODE)) &&
                       ({1'b0, code_off} < 9'(GLYPH_COUNT));
    assign in_op     = t_op'(s_axis_tuser);
    assign in_keep   = (in_op == OP_BEGIN) || (in_op == OP_PLACE);
    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign rd_idx    = in_inside ? code_off[GIDX_W-1:0] : '0;

    assign in_glyph.adv = s_axis_tdata[23:8];
    assign in_glyph.bx  = s_axis_tdata[39:24];
    assign in_glyph.by  = s_axis_tdata[55:40];
    assign in_glyph.w   = s_axis_tdata[63:56];
    assign in_glyph.h   = s_axis_tdata[71:64];
    assign in_glyph.u0  = s_axis_tdata[87:72];
    assign in_glyph.u1  = s_axis_tdata[103:88];
    assign in_glyph.v0  = s_axis_tdata[119:104];
    assign in_glyph.v1  = s_axis_tdata[135:120];

    assign mem_wr.en   = s_acc && (in_op == OP_LOAD) && in_inside;
    assign mem_wr.idx  = rd_idx;
    assign mem_wr.data = in_glyph;

    gqtl_glyph_mem u_glyph_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (mem_wr),
        .i_rd_en   (s_acc),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_glyph)
    );

    // ---------------- pipeline control ----------------
    logic r1_v, r2_v, r3_v, r4_v, r_ov;
    logic r1_begin, r2_begin;
    logic rdy1, rdy2, rdy3, rdy4, rdy_o;
    logic leave1, leave2;

    assign rdy_o  = !r_ov || m_axis_tready;
    assign rdy4   = !r4_v || rdy_o;
    assign rdy3   = !r3_v || rdy4;
    // a begin item drops out after the pen stage
    assign rdy2   = !r2_v || r2_begin || rdy3;
    assign rdy1   = !r1_v || rdy2;
    assign leave1 = r1_v && rdy2;
    assign leave2 = r2_v && rdy2;

    assign s_axis_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_v <= s_acc && in_keep;
            end
            if (rdy2) begin
                r2_v <= r1_v;
            end
            if (rdy3) begin
                r3_v <= r2_v && !r2_begin;
            end
            if (rdy4) begin
                r4_v <= r3_v;
            end
            if (rdy_o) begin
                r_ov <= r4_v;
            end
        end
    end

    // ---------------- stage 1: glyph read, multipliers ----------------
    logic                    r1_inside;
    logic [MULT_W-1:0]       r_size_mult;
    logic [15:0]             mul_a;
    logic [MULT_W-1:0]       mul_m;
    logic [37:0]             prod_a;
    logic signed [38:0]      prod_bx;
    logic signed [38:0]      prod_by;
    logic [29:0]             prod_w;
    logic [29:0]             prod_h;
    logic signed [MULT_W:0]  m_signed;
    logic                    s1_drawn;

    always_ff @(posedge i_clk) begin
        if (s_acc && rdy1) begin
            r1_begin  <= (in_op == OP_BEGIN);
            r1_inside <= in_inside;
        end
    end

    // the begin item scales the ascent with the fresh multiplier
    assign mul_a = r1_begin ? r_font_ascent : (r1_inside ? rd_glyph.adv : OOR_ADVANCE);
    assign mul_m = r1_begin ? r_m_cfg : r_size_mult;
    assign prod_a = mul_a * mul_m;

    assign m_signed = {1'b0, r_size_mult};
    assign prod_bx  = rd_glyph.bx * m_signed;
    assign prod_by  = rd_glyph.by * m_signed;
    assign prod_w   = rd_glyph.w * r_size_mult;
    assign prod_h   = rd_glyph.h * r_size_mult;
    assign s1_drawn = r1_inside && (rd_glyph.w != '0) && (rd_glyph.h != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_mult <= '0;
        end else if (leave1 && r1_begin) begin
            r_size_mult <= r_m_cfg;
        end
    end

    // ---------------- stage 2: pen and baseline ----------------
    logic [37:0]             r2_prod_a;
    logic signed [38:0]      r2_prod_bx;
    logic signed [38:0]      r2_prod_by;
    logic [29:0]             r2_prod_w;
    logic [29:0]             r2_prod_h;
    logic                    r2_drawn;
    logic [63:0]             r2_tex;
    logic [37:0]             prod_a_rnd;
    logic [MULT_W-1:0]       delta;
    logic signed [25:0]      pen_sum;
    logic signed [POS_W-1:0] pen_new;
    logic signed [25:0]      y_sum;
    logic signed [25:0]      y_adj;
    logic signed [15:0]      baseline_new;
    logic signed [POS_W-1:0] r_pen_x;
    logic signed [15:0]      r_baseline;

    always_ff @(posedge i_clk) begin
        if (leave1) begin
            r2_begin   <= r1_begin;
            r2_prod_a  <= prod_a;
            r2_prod_bx <= prod_bx;
            r2_prod_by <= prod_by;
            r2_prod_w  <= prod_w;
            r2_prod_h  <= prod_h;
            r2_drawn   <= s1_drawn;
            r2_tex     <= {rd_glyph.v1, rd_glyph.v0, rd_glyph.u1, rd_glyph.u0};
        end
    end

    assign prod_a_rnd   = r2_prod_a + 38'd32768;
    assign delta        = prod_a_rnd[37:16];
    assign pen_sum      = {{2{r_pen_x[23]}}, r_pen_x} + {4'b0, delta};
    assign pen_new      = sat24(pen_sum);
    assign y_sum        = {{2{r_origin_y[23]}}, r_origin_y} + {4'b0, delta};
    // round half away from zero: add half, less one when negative
    assign y_adj        = y_sum + 26'sd128 - {25'b0, y_sum[25]};
    assign baseline_new = sat16(y_adj[25:8]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x    <= '0;
            r_baseline <= '0;
        end else if (leave2) begin
            if (r2_begin) begin
                r_pen_x    <= r_origin_x;
                r_baseline <= baseline_new;
            end else begin
                r_pen_x <= pen_new;
            end
        end
    end

    // ---------------- stage 3: left and top ----------------
    logic signed [POS_W-1:0] r3_pen_before;
    logic signed [POS_W-1:0] r3_pen_after;
    logic signed [15:0]      r3_bl;
    logic signed [38:0]      r3_prod_bx;
    logic signed [38:0]      r3_prod_by;
    logic [29:0]             r3_prod_w;
    logic [29:0]             r3_prod_h;
    logic                    r3_drawn;
    logic [63:0]             r3_tex;
    logic signed [40:0]      l_sum;
    logic signed [40:0]      l_adj;
    logic signed [40:0]      t_sum;
    logic signed [40:0]      t_adj;

    always_ff @(posedge i_clk) begin
        if (leave2 && !r2_begin) begin
            r3_pen_before <= r_pen_x;
            r3_pen_after  <= pen_new;
            r3_bl         <= r_baseline;
            r3_prod_bx    <= r2_prod_bx;
            r3_prod_by    <= r2_prod_by;
            r3_prod_w     <= r2_prod_w;
            r3_prod_h     <= r2_prod_h;
            r3_drawn      <= r2_drawn;
            r3_tex        <= r2_tex;
        end
    end

    assign l_sum = {r3_pen_before[23], r3_pen_before, 16'b0} +
                   {{2{r3_prod_bx[38]}}, r3_prod_bx};
    assign l_adj = l_sum + 41'sd8388608 - {40'b0, l_sum[40]};
    assign t_sum = {r3_bl[15], r3_bl, 24'b0} - {{2{r3_prod_by[38]}}, r3_prod_by};
    assign t_adj = t_sum + 41'sd8388608 - {40'b0, t_sum[40]};

    // ---------------- stage 4: right and bottom ----------------
    logic signed [16:0]      r4_l;
    logic signed [16:0]      r4_t;
    logic [29:0]             r4_prod_w;
    logic [29:0]             r4_prod_h;
    logic                    r4_drawn;
    logic [63:0]             r4_tex;
    logic signed [POS_W-1:0] r4_pen_after;
    logic signed [33:0]      r_sum;
    logic signed [33:0]      r_adj;
    logic signed [33:0]      b_sum;
    logic signed [33:0]      b_adj;

    always_ff @(posedge i_clk) begin
        if (r3_v && rdy4) begin
            r4_l         <= l_adj[40:24];
            r4_t         <= t_adj[40:24];
            r4_prod_w    <= r3_prod_w;
            r4_prod_h    <= r3_prod_h;
            r4_drawn     <= r3_drawn;
            r4_tex       <= r3_tex;
            r4_pen_after <= r3_pen_after;
        end
    end

    // right and bottom build on the unsaturated left and top
    assign r_sum = {r4_l[16], r4_l, 16'b0} + {4'b0, r4_prod_w};
    assign r_adj = r_sum + 34'sd32768 - {33'b0, r_sum[33]};
    assign b_sum = {r4_t[16], r4_t, 16'b0} + {4'b0, r4_prod_h};
    assign b_adj = b_sum + 34'sd32768 - {33'b0, b_sum[33]};

    // ---------------- output register ----------------
    logic                    r_o_drawn;
    logic signed [EDGE_W-1:0] r_o_left, r_o_top, r_o_right, r_o_bottom;
    logic [63:0]             r_o_tex;
    logic signed [POS_W-1:0] r_o_pen;

    always_ff @(posedge i_clk) begin
        if (r4_v && rdy_o) begin
            r_o_drawn  <= r4_drawn;
            r_o_left   <= r4_drawn ? sat16({r4_l[16], r4_l}) : '0;
            r_o_top    <= r4_drawn ? sat16({r4_t[16], r4_t}) : '0;
            r_o_right  <= r4_drawn ? sat16(r_adj[33:16]) : '0;
            r_o_bottom <= r4_drawn ? sat16(b_adj[33:16]) : '0;
            r_o_tex    <= r4_drawn ? r4_tex : '0;
            r_o_pen    <= r4_pen_after;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_o_drawn;
    assign m_axis_tdata  = {r_o_pen, r_o_tex, r_o_bottom, r_o_right, r_o_top, r_o_left};

endmodule

[hw/rtl/gqtl_checker.sv]
// Port-level checker for the glyph quad text layout unit, bound to the top level.
module gqtl_checker
    import gqtl_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    // no result can come out right after reset: the past reset samples must all be high
    a_no_early_result: assert property (@(posedge i_clk)
        m_axis_tvalid |-> ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)))
        else $error("result shown too soon after reset");

    // a stalled result transaction holds its payload
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // an undrawn character carries zero quad and texture fields
    a_undrawn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[127:0] == '0))
        else $error("undrawn result has nonzero quad fields");

    // with the output register empty the input side must be open
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output is empty");

endmodule

bind glyph_quad_text_layout_unit gqtl_checker u_gqtl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
